### src/text_console_writer_unit_assert.svh
// Assertion macros shared by the console writer checker.
// Depends on nothing; included by the checker file only.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked on every rising edge outside reset.
`define TCW_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

### src/tcw_pkg.sv
// Shared constants, codes and the command type of the console writer.
// No dependencies; used by every module of the block.
package tcw_pkg;

	localparam int COLUMNS_DEF     = 80;
	localparam int ROWS_DEF        = 25;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;
	localparam logic [7:0] BLANK_CHAR       = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR     = 8'h0A;
	localparam logic [7:0] BACKSPACE_CHAR   = 8'h08;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [2:0] KIND_NOP       = 3'd0;
	localparam logic [2:0] KIND_CHAR      = 3'd1;
	localparam logic [2:0] KIND_NEWLINE   = 3'd2;
	localparam logic [2:0] KIND_BACKSPACE = 3'd3;
	localparam logic [2:0] KIND_CLEAR     = 3'd4;
	localparam logic [2:0] KIND_READ      = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [10:0] idx;
	} cmd_t;

endpackage

### src/tcw_front.sv
// Front end: takes items from the command port, classifies them, and
// pushes the decoded command into the queue. Depends on tcw_pkg.
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	input  logic [7:0]         char_code,
	input  logic [10:0]        cell_index,
	input  logic               init_busy,
	input  logic               q_full,
	output logic               busy,
	output logic               push,
	output tcw_pkg::cmd_t      cmd
);

	localparam int CELLS = ROWS * COLUMNS;

	tcw_pkg::cmd_t cmd_c;
	tcw_pkg::cmd_t cmd_s1;
	logic          valid_s1;
	logic          accept;

	always_comb begin
		cmd_c.ch  = char_code;
		cmd_c.idx = cell_index;
		case (opcode)
			tcw_pkg::OP_PUT: begin
				if (char_code == tcw_pkg::NEWLINE_CHAR) begin
					cmd_c.kind = tcw_pkg::KIND_NEWLINE;
				end else if (char_code == tcw_pkg::BACKSPACE_CHAR) begin
					cmd_c.kind = tcw_pkg::KIND_BACKSPACE;
				end else begin
					cmd_c.kind = tcw_pkg::KIND_CHAR;
				end
			end
			tcw_pkg::OP_CLEAR: cmd_c.kind = tcw_pkg::KIND_CLEAR;
			tcw_pkg::OP_READ: begin
				// out-of-range reads report a zero word, like an unused opcode
				if (32'(cell_index) < 32'(CELLS)) begin
					cmd_c.kind = tcw_pkg::KIND_READ;
				end else begin
					cmd_c.kind = tcw_pkg::KIND_NOP;
				end
			end
			default: cmd_c.kind = tcw_pkg::KIND_NOP;
		endcase
	end

	assign busy   = init_busy || (valid_s1 && q_full);
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_full;
	assign cmd    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

### src/tcw_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on tcw_pkg for the command type.
module tcw_queue #(
	parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t cmd_in,
	input  logic          pop,
	output tcw_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	tcw_pkg::cmd_t   slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNTW'(DEPTH));
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

### src/tcw_back.sv
// Back end: owns the screen memory and cursor, executes queued commands,
// runs scroll, clear and reset sweeps, and registers the result. Uses tcw_pkg.
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    text_color,
	input  tcw_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          init_busy,
	output logic          done,
	output logic [10:0]   cursor_position,
	output logic [15:0]   cell_word
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;

	logic [15:0]   screen_q [CELLS];
	logic [15:0]   rd_data_q;

	logic [2:0]    state_q, state_d;
	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic          cp_valid_s1, cp_valid_d;
	logic [AW-1:0] cp_addr_s1;
	logic          done_q;
	logic [10:0]   pos_q;
	logic [15:0]   word_q;

	logic          we, re, report;
	logic [AW-1:0] wa, ra, cur_addr;
	logic [15:0]   wd, word_d;
	logic [10:0]   pos_d;
	logic          last_col, last_row;

	assign cur_addr  = AW'(AW'(row_q) * AW'(COLUMNS) + AW'(col_q));
	assign last_col  = (col_q == CW'(COLUMNS - 1));
	assign last_row  = (row_q == RW'(ROWS - 1));
	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign init_busy = (state_q == ST_INIT);

	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		ptr_d      = ptr_q;
		cp_valid_d = 1'b0;
		we         = 1'b0;
		wa         = cur_addr;
		wd         = {text_color, tcw_pkg::BLANK_CHAR};
		re         = 1'b0;
		ra         = ptr_q;
		report     = 1'b0;
		word_d     = '0;

		// drain the copy pipeline first
		if (cp_valid_s1) begin
			we = 1'b1;
			wa = cp_addr_s1;
			wd = rd_data_q;
		end

		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				wa = ptr_q;
				wd = {tcw_pkg::TEXT_COLOR_RESET, tcw_pkg::BLANK_CHAR};
				if (ptr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					case (head.kind)
						tcw_pkg::KIND_CHAR, tcw_pkg::KIND_NEWLINE: begin
							if (head.kind == tcw_pkg::KIND_CHAR) begin
								we = 1'b1;
								wd = {text_color, head.ch};
							end
							if (head.kind == tcw_pkg::KIND_CHAR && !last_col) begin
								col_d  = col_q + 1'b1;
								report = 1'b1;
							end else begin
								col_d = '0;
								if (!last_row) begin
									row_d  = row_q + 1'b1;
									report = 1'b1;
								end else begin
									state_d = ST_SCROLL;
									ptr_d   = '0;
								end
							end
						end
						tcw_pkg::KIND_BACKSPACE: begin
							report = 1'b1;
							if (col_q != '0 || row_q != '0) begin
								we = 1'b1;
								wa = cur_addr - 1'b1;
								if (col_q == '0) begin
									row_d = row_q - 1'b1;
									col_d = CW'(COLUMNS - 1);
								end else begin
									col_d = col_q - 1'b1;
								end
							end
						end
						tcw_pkg::KIND_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							ptr_d   = '0;
							state_d = ST_FILL;
						end
						tcw_pkg::KIND_READ: begin
							re      = 1'b1;
							ra      = AW'(head.idx);
							state_d = ST_READ;
						end
						default: report = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				report  = 1'b1;
				word_d  = rd_data_q;
				state_d = ST_IDLE;
			end
			ST_SCROLL: begin
				// read one row below, write it back in the following cycle
				re         = 1'b1;
				ra         = ptr_q + AW'(COLUMNS);
				cp_valid_d = 1'b1;
				if (ptr_q == AW'(CELLS - COLUMNS - 1)) begin
					ptr_d   = AW'(CELLS - COLUMNS);
					state_d = ST_FILL;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_FILL: begin
				if (!cp_valid_s1) begin
					we = 1'b1;
					wa = ptr_q;
					if (ptr_q == AW'(CELLS - 1)) begin
						report  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign pos_d = 11'(AW'(row_d) * AW'(COLUMNS) + AW'(col_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			ptr_q       <= '0;
			cp_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			col_q       <= col_d;
			ptr_q       <= ptr_d;
			cp_valid_s1 <= cp_valid_d;
			done_q      <= report;
		end
	end

	always_ff @(posedge clk) begin
		if (cp_valid_d) begin
			cp_addr_s1 <= ptr_q;
		end
		if (report) begin
			pos_q  <= pos_d;
			word_q <= word_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			screen_q[wa] <= wd;
		end
		if (re) begin
			rd_data_q <= screen_q[ra];
		end
	end

	assign done            = done_q;
	assign cursor_position = pos_q;
	assign cell_word       = word_q;

endmodule

### src/text_console_writer_unit.sv
// Top level of the text console writer: configuration register and the
// front end, command queue and back end. Depends on tcw_pkg and its modules.
//
// Usage:
//   Command channel: drive opcode, char_code and cell_index with start high;
//   the item is taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with cursor_position and
//   cell_word; the receiver cannot stall, so every result must be taken then.
//   Configuration: text_color is written at any edge with text_color_we high;
//   change it only while no item is outstanding.
// Path: the front register, the queue, the back end, then the done register;
//   an in-range read adds one registered memory read. Puts run one per cycle in
//   the back end: one item per cycle is sustained outside reads and sweeps.
// A newline on the last row, or a wrap there, scrolls: the back end walks
//   ROWS*COLUMNS-COLUMNS cell copies plus a COLUMNS-cell blank fill. A clear
//   fills ROWS*COLUMNS cells, one per cycle. The screen memory takes one write
//   per cycle; items queue meanwhile and busy rises once the queue and front
//   register fill.
// Reset: the cursor homes and the back end sweeps all ROWS*COLUMNS cells (2000
//   by default) to spaces in attribute 0x07 with busy held high.
module text_console_writer_unit #(
	parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS        = tcw_pkg::ROWS_DEF,
	parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_index,
	input  logic        text_color_we,
	input  logic [7:0]  text_color,
	output logic        done,
	output logic [10:0] cursor_position,
	output logic [15:0] cell_word
);

	logic [7:0]    text_color_q;
	logic          init_busy;
	logic          push, pop;
	logic          q_empty, q_full;
	tcw_pkg::cmd_t front_cmd;
	tcw_pkg::cmd_t head_cmd;

	// hold the attribute used for written and blanked cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tcw_pkg::TEXT_COLOR_RESET;
		end else if (text_color_we) begin
			text_color_q <= text_color;
		end
	end

	// classify items and hand them to the queue
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (opcode),
		.char_code (char_code),
		.cell_index(cell_index),
		.init_busy (init_busy),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.cmd       (front_cmd)
	);

	// decouple intake from long back-end sweeps
	tcw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.cmd_in(front_cmd),
		.pop   (pop),
		.head  (head_cmd),
		.empty (q_empty),
		.full  (q_full)
	);

	// execute commands against the screen and the cursor
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_color     (text_color_q),
		.head           (head_cmd),
		.q_empty        (q_empty),
		.pop            (pop),
		.init_busy      (init_busy),
		.done           (done),
		.cursor_position(cursor_position),
		.cell_word      (cell_word)
	);

endmodule

### src/tcw_checker.sv
// Port-level checker for the console writer, bound to the top level.
// Depends on text_console_writer_unit_assert.svh for the assertion macros.
`include "text_console_writer_unit_assert.svh"

module tcw_checker #(
	parameter int CELLS       = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int MAX_PENDING = tcw_pkg::QUEUE_DEPTH_DEF + 3
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [10:0] cursor_position
);

	logic [7:0] pending_q;

	// count items taken but not yet reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if ((start && !busy) && !done) begin
			pending_q <= pending_q + 1'b1;
		end else if (done && !(start && !busy)) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`TCW_ASSERT_IMP(a_busy_after_reset, clk, arst_n, $past(!arst_n), busy, "no clearing pass after reset")
	`TCW_ASSERT_IMP(a_no_spurious_result, clk, arst_n, done, pending_q != 8'd0, "result without item")
	`TCW_ASSERT_ALWAYS(a_pending_bound, clk, arst_n, pending_q <= 8'(MAX_PENDING), "too many items in flight")
	`TCW_ASSERT_IMP(a_cursor_range, clk, arst_n, done, (CELLS > 2048) || (32'(cursor_position) < 32'(CELLS)), "cursor out of range")

endmodule

bind text_console_writer_unit tcw_checker #(
	.CELLS      (COLUMNS * ROWS),
	.MAX_PENDING(QUEUE_DEPTH + 3)
) u_tcw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.cursor_position(cursor_position)
);
